@@ rtl/sorted_priority_queue_unit_defines.svh @@
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger; clocked on i_clk, off in reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
// Shared constants, codes and types of the sorted priority queue.
package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PRIO_WIDTH = 8;

    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Per-cell command for the current request.
    typedef struct packed {
        logic push;
        logic pop;
        logic upd;
    } t_cell_ctrl;

endpackage

@@ rtl/sorted_priority_queue_unit.sv @@
// Top level of the sorted priority queue: cell chain, occupancy count and stream ports.
// A bounded priority queue of DEPTH entries kept sorted in a chain of cells, highest
// priority at the head (cell 0). Each request carries an action in tuser: push inserts
// the data word behind every stored entry of greater or equal priority (equal
// priorities leave in arrival order), pop removes the head, update replaces the head's
// data; the unused action code does nothing. Every request yields one result with the
// head's data and priority (zero when empty), a head-valid flag, the occupancy and a
// status in tuser: ok, pop or update on an empty queue, or push on a full queue (the
// entry is dropped). Errored requests change nothing. All cells compare against the
// incoming priority and shift by one place in parallel at the same edge, so a request
// is accepted every cycle while results are taken; the result register lets the next
// request in at the edge that hands the old result out. No clearing pass follows reset;
// the queue is empty as soon as reset is released.
module sorted_priority_queue_unit #(
    parameter int DEPTH      = spq_pkg::DEPTH,
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata: data_value, prio, zero fill
    input  logic [((DATA_WIDTH + PRIO_WIDTH + 7) / 8) * 8 - 1:0]
                                      i_s_axis_tdata,
    // tuser: action
    input  logic [spq_pkg::ACT_W-1:0] i_s_axis_tuser,
    // Result channel
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // tdata: head_data, head_prio, head_valid, occupancy, zero fill
    output logic [((DATA_WIDTH + PRIO_WIDTH + $clog2(DEPTH + 1) + 8) / 8) * 8 - 1:0]
                                      o_m_axis_tdata,
    // tuser: status
    output logic [spq_pkg::STAT_W-1:0] o_m_axis_tuser
);

    `include "sorted_priority_queue_unit_defines.svh"

    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int IN_W   = DATA_WIDTH + PRIO_WIDTH;
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = DATA_WIDTH + PRIO_WIDTH + 1 + OCC_W;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    // Request fields
    logic                       w_in_acc;
    logic [spq_pkg::ACT_W-1:0]  w_act;
    logic [DATA_WIDTH-1:0]      w_new_data;
    logic [PRIO_WIDTH-1:0]      w_new_prio;

    // Control and bookkeeping
    logic [OCC_W-1:0]           r_count, n_count;
    logic [spq_pkg::STAT_W-1:0] r_status, n_status;
    logic                       r_out_valid;
    logic                       w_full, w_empty;
    logic                       w_do_push, w_do_pop, w_do_upd;

    // Chain taps
    logic [DATA_WIDTH-1:0]      w_data [DEPTH];
    logic [PRIO_WIDTH-1:0]      w_prio [DEPTH];
    logic [DEPTH-1:0]           w_valid;
    logic [DEPTH-1:0]           w_keep;

    // Head of the queue as reported
    logic [DATA_WIDTH-1:0]      w_head_data;
    logic [PRIO_WIDTH-1:0]      w_head_prio;

    // Accept a new request at the edge that hands the previous result out.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_act      = i_s_axis_tuser;
    assign w_new_data = i_s_axis_tdata[DATA_WIDTH-1:0];
    assign w_new_prio = i_s_axis_tdata[IN_W-1:DATA_WIDTH];

    assign w_full  = (r_count == OCC_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // Drop errored requests before they reach the cells.
    assign w_do_push = w_in_acc && (w_act == spq_pkg::ACT_PUSH)   && !w_full;
    assign w_do_pop  = w_in_acc && (w_act == spq_pkg::ACT_POP)    && !w_empty;
    assign w_do_upd  = w_in_acc && (w_act == spq_pkg::ACT_UPDATE) && !w_empty;

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        unique case (w_act)
            spq_pkg::ACT_PUSH: begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + OCC_W'(1);
                end
            end
            spq_pkg::ACT_POP: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - OCC_W'(1);
                end
            end
            spq_pkg::ACT_UPDATE: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end
            end
            default: begin
                n_status = spq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_status    <= spq_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= n_count;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Build the cell chain; the head sees a left neighbor that always keeps,
    // the tail pulls in an empty slot on pop.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        spq_pkg::t_cell_ctrl   w_ctrl;
        logic                  w_lkeep;
        logic [DATA_WIDTH-1:0] w_ldata;
        logic [PRIO_WIDTH-1:0] w_lprio;
        logic                  w_lvalid;
        logic [DATA_WIDTH-1:0] w_rdata;
        logic [PRIO_WIDTH-1:0] w_rprio;
        logic                  w_rvalid;

        assign w_ctrl.push = w_do_push;
        assign w_ctrl.pop  = w_do_pop;
        assign w_ctrl.upd  = (gi == 0) ? w_do_upd : 1'b0;

        if (gi == 0) begin : g_head
            assign w_lkeep  = 1'b1;
            assign w_ldata  = '0;
            assign w_lprio  = '0;
            assign w_lvalid = 1'b0;
        end else begin : g_body
            assign w_lkeep  = w_keep[gi-1];
            assign w_ldata  = w_data[gi-1];
            assign w_lprio  = w_prio[gi-1];
            assign w_lvalid = w_valid[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_rdata  = '0;
            assign w_rprio  = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_mid
            assign w_rdata  = w_data[gi+1];
            assign w_rprio  = w_prio[gi+1];
            assign w_rvalid = w_valid[gi+1];
        end

        spq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new_data    (w_new_data),
            .i_new_prio    (w_new_prio),
            .i_left_keep   (w_lkeep),
            .i_left_data   (w_ldata),
            .i_left_prio   (w_lprio),
            .i_left_valid  (w_lvalid),
            .i_right_data  (w_rdata),
            .i_right_prio  (w_rprio),
            .i_right_valid (w_rvalid),
            .o_data        (w_data[gi]),
            .o_prio        (w_prio[gi]),
            .o_valid       (w_valid[gi]),
            .o_keep        (w_keep[gi])
        );
    end

    // The head cell and count already hold the state after the last request.
    assign w_head_data = w_valid[0] ? w_data[0] : '0;
    assign w_head_prio = w_valid[0] ? w_prio[0] : '0;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = OUT_TW'({r_count, w_valid[0], w_head_prio, w_head_data});

    // Valid cells form a prefix of the chain, and their number is the count.
    `SPQ_ASSERT_NOW(a_valid_prefix, 1'b1,
        ((w_valid & (w_valid + DEPTH'(1))) == '0) && ($countones(w_valid) == r_count),
        "cell valid bits are not a prefix matching the count")

    // A push that fits grows the queue by one.
    `SPQ_ASSERT_NEXT(a_push_grows, w_do_push, r_count == $past(r_count) + OCC_W'(1),
        "accepted push did not grow the queue")

    // A full-queue push reports the drop and leaves the count alone.
    `SPQ_ASSERT_NEXT(a_full_drop,
        w_in_acc && (w_act == spq_pkg::ACT_PUSH) && w_full,
        (r_status == spq_pkg::ST_FULL) && (r_count == $past(r_count)),
        "push on full queue was not dropped")

    // Neighboring valid entries stay in non-increasing priority order.
    for (genvar gj = 0; gj < DEPTH - 1; gj++) begin : g_chk
        `SPQ_ASSERT_NOW(a_sorted, w_valid[gj+1], w_prio[gj] >= w_prio[gj+1],
            "chain lost priority order")
    end

endmodule

@@ rtl/spq_cell.sv @@
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
module spq_cell #(
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spq_pkg::t_cell_ctrl   i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_new_data,
    input  logic [PRIO_WIDTH-1:0] i_new_prio,
    input  logic                  i_left_keep,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic [PRIO_WIDTH-1:0] i_left_prio,
    input  logic                  i_left_valid,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic [PRIO_WIDTH-1:0] i_right_prio,
    input  logic                  i_right_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [PRIO_WIDTH-1:0] o_prio,
    output logic                  o_valid,
    output logic                  o_keep
);

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic [PRIO_WIDTH-1:0] r_prio, n_prio;
    logic                  r_valid, n_valid;

    // Entry stays on push when it ranks at or above the newcomer.
    assign o_keep = r_valid && (r_prio >= i_new_prio);

    always_comb begin
        n_data  = r_data;
        n_prio  = r_prio;
        n_valid = r_valid;
        if (i_ctrl.push) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_data  = i_new_data;
                    n_prio  = i_new_prio;
                    n_valid = 1'b1;
                end else begin
                    n_data  = i_left_data;
                    n_prio  = i_left_prio;
                    n_valid = i_left_valid;
                end
            end
        end else if (i_ctrl.pop) begin
            n_data  = i_right_data;
            n_prio  = i_right_prio;
            n_valid = i_right_valid;
        end else if (i_ctrl.upd) begin
            n_data = i_new_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_prio  = r_prio;
    assign o_valid = r_valid;

endmodule
